// File: hdl/strict_priority_call_scheduler_assert.svh
// Assertion macros for the strict priority call scheduler.
// Users must have aclk and aresetn in scope; define NO_ASSERTIONS to drop them.
`ifndef STRICT_PRIORITY_CALL_SCHEDULER_ASSERT_SVH
`define STRICT_PRIORITY_CALL_SCHEDULER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on aclk, off during reset
`define SPS_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("strict priority scheduler assertion failed");

// Next-cycle implication, sampled on aclk, off during reset
`define SPS_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("strict priority scheduler assertion failed");

`else

`define SPS_ASSERT_IMP(name, ante, cons)
`define SPS_ASSERT_NXT(name, ante, cons)

`endif

`endif

// File: hdl/sps_pkg.sv
// Shared types and constants for the strict priority call scheduler.
// No dependencies; used by sps_queues and the top level.
package sps_pkg;

    localparam int NUM_CLASSES = 4;
    localparam int CLS_W       = 2;
    localparam int ID_W        = 16;
    localparam int SVC_W       = 16;
    localparam int ENTRY_W     = ID_W + SVC_W;
    localparam int TICK_W      = 32;

    // Stream widths, padded to whole bytes
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 56;

    // Input tdata layout
    localparam int S_CLS_LSB = 0;
    localparam int S_ID_LSB  = S_CLS_LSB + CLS_W;
    localparam int S_SVC_LSB = S_ID_LSB + ID_W;
    localparam int S_USED_W  = S_SVC_LSB + SVC_W;

    // Result tdata layout
    localparam int M_TICK_LSB = 0;
    localparam int M_ACC_BIT  = M_TICK_LSB + TICK_W;
    localparam int M_DROP_BIT = M_ACC_BIT + 1;
    localparam int M_AV_BIT   = M_DROP_BIT + 1;
    localparam int M_ID_LSB   = M_AV_BIT + 1;
    localparam int M_CLS_LSB  = M_ID_LSB + ID_W;
    localparam int M_BUSY_BIT = M_CLS_LSB + CLS_W;
    localparam int M_IDLE_BIT = M_BUSY_BIT + 1;
    localparam int M_USED_W   = M_IDLE_BIT + 1;

    typedef enum logic {
        KIND_ARRIVAL = 1'b0,
        KIND_TICK    = 1'b1
    } kind_t;

    // Queue word: service length high, requester id low
    typedef struct packed {
        logic [SVC_W-1:0] svc;
        logic [ID_W-1:0]  id;
    } entry_t;

    // Request from the top level to the queue block
    typedef struct packed {
        logic             fire;
        kind_t            kind;
        logic [CLS_W-1:0] cls;
        entry_t           entry;
        logic             svc_idle;
    } sps_cmd_t;

    // Outcome of one item in the queue block
    typedef struct packed {
        logic             accepted;
        logic             dropped;
        logic             ans_valid;
        logic [CLS_W-1:0] ans_cls;
        entry_t           ans_entry;
        logic             all_empty;
    } sps_res_t;

endpackage

// File: hdl/sps_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hdl/sps_queues.sv
// Four class FIFOs with a two-entry head cache per class and a shared RAM,
// plus the highest-class pick. Depends on sps_pkg and sps_ram.
module sps_queues
    import sps_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  sps_cmd_t cmd,
    output sps_res_t res
);

    localparam int QW        = $clog2(DEPTH);
    localparam int CW        = $clog2(DEPTH + 1);
    localparam int AW        = CLS_W + QW;
    localparam int RAM_DEPTH = NUM_CLASSES * (2 ** QW);

    localparam logic [QW:0]   DEPTH_X = (QW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    // Bring a ring position below twice the depth back into range
    function automatic logic [QW-1:0] wrap_idx(input logic [QW:0] v);
        logic [QW:0] w;
        begin
            w = (v >= DEPTH_X) ? (v - DEPTH_X) : v;
            return w[QW-1:0];
        end
    endfunction

    logic [QW-1:0]    head_reg     [NUM_CLASSES];
    logic [QW-1:0]    head_next    [NUM_CLASSES];
    logic [CW-1:0]    cnt_reg      [NUM_CLASSES];
    logic [CW-1:0]    cnt_next     [NUM_CLASSES];
    entry_t           h0_reg       [NUM_CLASSES];
    entry_t           h0_next      [NUM_CLASSES];
    entry_t           h1_reg       [NUM_CLASSES];
    entry_t           h1_next      [NUM_CLASSES];
    entry_t           h1_eff       [NUM_CLASSES];
    logic             pend_reg;
    logic             pend_next;
    logic [CLS_W-1:0] pend_cls_reg;
    logic [CLS_W-1:0] pend_cls_next;

    logic             pick_vld;
    logic [CLS_W-1:0] pick_cls;
    logic             do_disp;
    logic             full;
    logic [QW-1:0]    tail_idx;
    logic [QW-1:0]    third_idx;
    logic [CW-1:0]    arr_cnt;
    logic [CW-1:0]    pick_cnt;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    entry_t        rd_data;

    // Entries past the second of each class live here
    sps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Second head entry, taking RAM data that arrived this cycle
    always_comb begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
            h1_eff[c] = (pend_reg && pend_cls_reg == CLS_W'(c)) ? rd_data : h1_reg[c];
        end
    end

    // Highest non-empty class wins
    always_comb begin
        pick_vld = 1'b0;
        pick_cls = '0;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            if (cnt_reg[c] != '0) begin
                pick_vld = 1'b1;
                pick_cls = CLS_W'(c);
            end
        end
    end

    // Ring positions for the tail write and the third-entry prefetch
    always_comb begin
        arr_cnt   = cnt_reg[cmd.cls];
        pick_cnt  = cnt_reg[pick_cls];
        full      = (arr_cnt == DEPTH_C);
        tail_idx  = wrap_idx({1'b0, head_reg[cmd.cls]} + (QW + 1)'(arr_cnt));
        third_idx = wrap_idx({1'b0, head_reg[pick_cls]} + (QW + 1)'(2));
        do_disp   = cmd.fire && (cmd.kind == KIND_TICK) && cmd.svc_idle && pick_vld;
    end

    // Enqueue, dequeue and head cache refill
    always_comb begin
        head_next     = head_reg;
        cnt_next      = cnt_reg;
        h0_next       = h0_reg;
        h1_next       = h1_eff;
        pend_next     = 1'b0;
        pend_cls_next = pend_cls_reg;
        wr_en         = 1'b0;
        wr_addr       = {cmd.cls, tail_idx};
        wr_data       = cmd.entry;
        rd_en         = 1'b0;
        rd_addr       = {pick_cls, third_idx};
        res           = '0;

        if (cmd.fire && cmd.kind == KIND_ARRIVAL) begin
            if (full) begin
                res.dropped = 1'b1;
            end else begin
                res.accepted       = 1'b1;
                wr_en              = 1'b1;
                cnt_next[cmd.cls]  = arr_cnt + CW'(1);
                if (arr_cnt == CW'(0)) begin
                    h0_next[cmd.cls] = cmd.entry;
                end
                if (arr_cnt == CW'(1)) begin
                    h1_next[cmd.cls] = cmd.entry;
                end
            end
        end

        if (do_disp) begin
            res.ans_valid      = 1'b1;
            res.ans_cls        = pick_cls;
            res.ans_entry      = h0_reg[pick_cls];
            h0_next[pick_cls]  = h1_eff[pick_cls];
            head_next[pick_cls] = wrap_idx({1'b0, head_reg[pick_cls]} + (QW + 1)'(1));
            cnt_next[pick_cls] = pick_cnt - CW'(1);
            // Fetch the new second entry from RAM
            if (pick_cnt > CW'(2)) begin
                rd_en         = 1'b1;
                pend_next     = 1'b1;
                pend_cls_next = pick_cls;
            end
        end

        res.all_empty = 1'b1;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            if (cnt_next[c] != '0) begin
                res.all_empty = 1'b0;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                head_reg[c] <= '0;
                cnt_reg[c]  <= '0;
            end
            pend_reg     <= 1'b0;
            pend_cls_reg <= '0;
        end else begin
            head_reg     <= head_next;
            cnt_reg      <= cnt_next;
            pend_reg     <= pend_next;
            pend_cls_reg <= pend_cls_next;
        end
    end

    // Head cache payload
    always_ff @(posedge aclk) begin
        h0_reg <= h0_next;
        h1_reg <= h1_next;
    end

endmodule

// File: hdl/strict_priority_call_scheduler.sv
// Strict priority call scheduler: one server, four class FIFOs.
// Users of the block see a slave stream of arrival and tick items and a
// master stream with one result item per accepted item.
// s_tuser carries the item kind (arrival or tick); s_tdata carries class,
// requester id and service length. Each result gives the tick number, the
// arrival outcome, the dispatched request if any, and busy/idle status.
// An item is held in the input register, processed, and its result lands
// in the output register, which drives m_tvalid. One item per cycle is
// sustained while m_tready stays high; the rate is set by the single
// combinational pass through the queue update and the highest-class pick,
// with the queue RAM read one item ahead into a two-entry head cache.
// Reset empties all FIFOs and clears the countdown and tick counter; queue
// RAM contents need no clearing, so items are taken right after reset.
// When m_tready is low the output register holds its item, the input
// register fills, and s_tready drops until the result is taken.
// Depends on sps_pkg, sps_queues and the assertion macro header.
`include "strict_priority_call_scheduler_assert.svh"

module strict_priority_call_scheduler
    import sps_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // priority_class, requester_id, service_ticks, zeros
    input  logic                 s_tuser,  // kind
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // tick_number, arrival_accepted, arrival_dropped,
                                           // answered_valid, answered_id, answered_class,
                                           // server_busy, all_idle, zeros
);

    logic             in_vld_reg;
    kind_t            in_kind_reg;
    logic [CLS_W-1:0] in_cls_reg;
    entry_t           in_entry_reg;

    logic                 out_vld_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [M_TDATA_W-1:0] out_data_next;

    logic [SVC_W-1:0]  svc_reg;
    logic [SVC_W-1:0]  svc_next;
    logic [SVC_W-1:0]  svc_load;
    logic [TICK_W-1:0] tick_reg;
    logic [TICK_W-1:0] tick_next;

    logic     proc_adv;
    logic     proc_fire;
    logic     tick_fire;
    logic     s_fire;
    sps_cmd_t cmd;
    sps_res_t res;

    // Handshake: process when the output register is free or being drained
    assign proc_adv  = !out_vld_reg || m_tready;
    assign proc_fire = in_vld_reg && proc_adv;
    assign tick_fire = proc_fire && (in_kind_reg == KIND_TICK);
    assign s_tready  = !in_vld_reg || proc_adv;
    assign s_fire    = s_tvalid && s_tready;
    assign m_tvalid  = out_vld_reg;
    assign m_tdata   = out_data_reg;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_kind_reg      <= kind_t'(s_tuser);
            in_cls_reg       <= s_tdata[S_CLS_LSB +: CLS_W];
            in_entry_reg.id  <= s_tdata[S_ID_LSB +: ID_W];
            in_entry_reg.svc <= s_tdata[S_SVC_LSB +: SVC_W];
        end
    end

    // Queue request
    always_comb begin
        cmd          = '0;
        cmd.fire     = proc_fire;
        cmd.kind     = in_kind_reg;
        cmd.cls      = in_cls_reg;
        cmd.entry    = in_entry_reg;
        cmd.svc_idle = (svc_reg == '0);
    end

    sps_queues #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queues (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .res     (res)
    );

    // Countdown and tick counter
    always_comb begin
        svc_load  = res.ans_valid ? res.ans_entry.svc : svc_reg;
        svc_next  = svc_reg;
        tick_next = tick_reg;
        if (tick_fire) begin
            svc_next  = (svc_load != '0) ? (svc_load - SVC_W'(1)) : '0;
            tick_next = tick_reg + TICK_W'(1);
        end
    end

    // Pack the result item
    always_comb begin
        out_data_next                            = '0;
        out_data_next[M_TICK_LSB +: TICK_W]      = tick_reg;
        out_data_next[M_ACC_BIT]                 = res.accepted;
        out_data_next[M_DROP_BIT]                = res.dropped;
        out_data_next[M_AV_BIT]                  = res.ans_valid;
        out_data_next[M_ID_LSB +: ID_W]          = res.ans_entry.id;
        out_data_next[M_CLS_LSB +: CLS_W]        = res.ans_cls;
        out_data_next[M_BUSY_BIT]                = (svc_next != '0);
        out_data_next[M_IDLE_BIT]                = res.all_empty && (svc_next == '0);
    end

    // Server state and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            svc_reg     <= '0;
            tick_reg    <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            svc_reg  <= svc_next;
            tick_reg <= tick_next;
            if (proc_adv) begin
                out_vld_reg <= in_vld_reg;
            end
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (proc_fire) begin
            out_data_reg <= out_data_next;
        end
    end

    // Checks; an arrival sets exactly one of accepted and dropped
    `SPS_ASSERT_IMP(a_disp_only_when_idle, proc_fire && res.ans_valid, svc_reg == '0)
    `SPS_ASSERT_NXT(a_tick_advances, tick_fire, tick_reg == $past(tick_reg) + TICK_W'(1))
    `SPS_ASSERT_NXT(a_arrival_outcome, proc_fire && !tick_fire, ^m_tdata[M_DROP_BIT:M_ACC_BIT])
    `SPS_ASSERT_IMP(a_idle_not_busy, m_tvalid && m_tdata[M_IDLE_BIT], !m_tdata[M_BUSY_BIT])

endmodule

// File: tb/strict_priority_call_scheduler_test.sv
`timescale 1ns / 1ps
// Self-checking bench for the strict priority call scheduler: a directed table, then
// random arrival/tick traffic, checked item by item against a scheduler predictor.
// Depends on sps_pkg and the strict_priority_call_scheduler top level.
module strict_priority_call_scheduler_test;
    import sps_pkg::*;

    localparam int QUEUE_DEPTH    = 16;
    localparam int TOTAL_ITEMS    = 1650;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int NUM_ROWS       = 17;

    typedef struct packed {
        logic [TICK_W-1:0] tick_number;
        logic              accepted;
        logic              dropped;
        logic              ans_valid;
        logic [ID_W-1:0]   ans_id;
        logic [CLS_W-1:0]  ans_cls;
        logic              busy;
        logic              idle;
    } sched_result_t;

    typedef struct packed {
        kind_t             kind;
        logic [CLS_W-1:0]  cls;
        logic [ID_W-1:0]   id;
        logic [SVC_W-1:0]  svc;
        logic [7:0]        reps;
        logic              typed;
        sched_result_t     want;
    } stim_row_t;

    typedef enum int {
        READY_ALWAYS,
        READY_ALTERNATE,
        READY_RANDOM,
        READY_HELD_OFF
    } ready_mode_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    // Predictor state: per-class request FIFOs, countdown and tick count
    entry_t            class_words [NUM_CLASSES][QUEUE_DEPTH];
    int                class_head  [NUM_CLASSES];
    int                class_count [NUM_CLASSES];
    logic [SVC_W-1:0]  svc_left;
    logic [TICK_W-1:0] tick_count;

    sched_result_t pending_results[$];
    stim_row_t     directed_rows [NUM_ROWS];

    int mismatch_count;
    int quiet_cycles;
    int items_sent;
    int dispatch_count;
    int drop_count;
    int burst_left;

    strict_priority_call_scheduler #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Queue an arrival or run one tick; return the result the block owes for it
    function automatic sched_result_t schedule_item(input kind_t k, input logic [CLS_W-1:0] cls,
                                                    input logic [ID_W-1:0] id,
                                                    input logic [SVC_W-1:0] svc);
        sched_result_t r;
        entry_t        word;
        int            c;
        r = '0;
        r.tick_number = tick_count;
        if (k == KIND_ARRIVAL) begin
            if (class_count[cls] >= QUEUE_DEPTH) begin
                r.dropped = 1'b1;
            end else begin
                class_words[cls][(class_head[cls] + class_count[cls]) % QUEUE_DEPTH] = {svc, id};
                class_count[cls]++;
                r.accepted = 1'b1;
            end
        end else begin
            // Idle server: take the head of the highest non-empty class
            if (svc_left == 0) begin
                for (c = NUM_CLASSES - 1; c >= 0 && !r.ans_valid; c--) begin
                    if (class_count[c] != 0) begin
                        word = class_words[c][class_head[c]];
                        class_head[c] = (class_head[c] + 1) % QUEUE_DEPTH;
                        class_count[c]--;
                        r.ans_valid = 1'b1;
                        r.ans_id = word.id;
                        r.ans_cls = c[CLS_W-1:0];
                        svc_left = word.svc;
                    end
                end
            end
            if (svc_left != 0) svc_left = svc_left - 1'b1;
            tick_count = tick_count + 1'b1;
        end
        r.busy = (svc_left != 0);
        r.idle = (svc_left == 0);
        for (c = 0; c < NUM_CLASSES; c++) begin
            if (class_count[c] != 0) r.idle = 1'b0;
        end
        return r;
    endfunction

    function automatic sched_result_t outcome(input logic [TICK_W-1:0] tick_number,
                                              input logic acc, input logic drop,
                                              input logic av, input logic [ID_W-1:0] id,
                                              input logic [CLS_W-1:0] cls,
                                              input logic busy, input logic idle);
        sched_result_t r;
        r = {tick_number, acc, drop, av, id, cls, busy, idle};
        return r;
    endfunction

    function automatic stim_row_t stim(input kind_t k, input logic [CLS_W-1:0] cls,
                                       input logic [ID_W-1:0] id, input logic [SVC_W-1:0] svc,
                                       input logic [7:0] reps, input logic typed,
                                       input sched_result_t want);
        stim_row_t row;
        row = {k, cls, id, svc, reps, typed, want};
        return row;
    endfunction

    function automatic string show(input sched_result_t r);
        return $sformatf("tick=%0d acc=%0b drop=%0b ans=%0b id=%h cls=%0d busy=%0b idle=%0b",
                         r.tick_number, r.accepted, r.dropped, r.ans_valid, r.ans_id,
                         r.ans_cls, r.busy, r.idle);
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("mismatch: %s", msg);
    endtask

    // Offer one item in bursts with random gaps, then record what it should produce
    task automatic send_item(input kind_t k, input logic [CLS_W-1:0] cls,
                             input logic [ID_W-1:0] id, input logic [SVC_W-1:0] svc,
                             input logic typed, input sched_result_t typed_want);
        logic [S_TDATA_W-1:0] word;
        sched_result_t        predicted;
        logic                 taken;
        int                   gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        word = '0;
        word[S_CLS_LSB +: CLS_W] = cls;
        word[S_ID_LSB +: ID_W] = id;
        word[S_SVC_LSB +: SVC_W] = svc;
        s_tvalid <= 1'b1;
        s_tuser <= k;
        s_tdata <= word;
        // Ready is sampled mid-cycle, so the edge that follows is the one that takes it
        do begin
            @(negedge aclk);
            taken = s_tready;
            @(posedge aclk);
        end while (!taken);
        predicted = schedule_item(k, cls, id, svc);
        pending_results.push_back(typed ? typed_want : predicted);
        items_sent++;
        if (predicted.ans_valid) dispatch_count++;
        if (predicted.dropped) drop_count++;
    endtask

    // Hold off the sender until every owed result has come back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Receiver back-pressure: a random mode held for a random stretch
    ready_mode_t ready_mode;
    int          mode_left;
    always @(posedge aclk) begin
        if (!aresetn) begin
            ready_mode = READY_ALWAYS;
            mode_left = 0;
            m_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode = ready_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 80);
            end else begin
                mode_left--;
            end
            case (ready_mode)
                READY_ALWAYS: begin
                    m_tready <= 1'b1;
                end
                READY_ALTERNATE: begin
                    m_tready <= mode_left[0];
                end
                READY_RANDOM: begin
                    m_tready <= ($urandom_range(0, 3) == 0);
                end
                default: begin
                    m_tready <= (mode_left < 4);
                end
            endcase
        end
    end

    // Check each result as it is taken, and watch for a stalled run
    always @(negedge aclk) begin : result_check
        sched_result_t seen;
        sched_result_t want;
        string         diffs;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                seen.tick_number = m_tdata[M_TICK_LSB +: TICK_W];
                seen.accepted = m_tdata[M_ACC_BIT];
                seen.dropped = m_tdata[M_DROP_BIT];
                seen.ans_valid = m_tdata[M_AV_BIT];
                seen.ans_id = m_tdata[M_ID_LSB +: ID_W];
                seen.ans_cls = m_tdata[M_CLS_LSB +: CLS_W];
                seen.busy = m_tdata[M_BUSY_BIT];
                seen.idle = m_tdata[M_IDLE_BIT];
                if (pending_results.size() == 0) begin
                    flag_mismatch({"result with nothing owed: ", show(seen)});
                end else begin
                    want = pending_results.pop_front();
                    diffs = "";
                    if (seen.tick_number != want.tick_number) diffs = {diffs, " tick_number"};
                    if (seen.accepted != want.accepted) diffs = {diffs, " arrival_accepted"};
                    if (seen.dropped != want.dropped) diffs = {diffs, " arrival_dropped"};
                    if (seen.ans_valid != want.ans_valid) diffs = {diffs, " answered_valid"};
                    if (seen.ans_id != want.ans_id) diffs = {diffs, " answered_id"};
                    if (seen.ans_cls != want.ans_cls) diffs = {diffs, " answered_class"};
                    if (seen.busy != want.busy) diffs = {diffs, " server_busy"};
                    if (seen.idle != want.idle) diffs = {diffs, " all_idle"};
                    if (diffs != "") begin
                        flag_mismatch($sformatf("fields%s differ\n  want %s\n  got  %s",
                                                diffs, show(want), show(seen)));
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
                $display("strict_priority_call_scheduler_test NOT OK");
                $finish;
            end
        end
    end

    initial begin
        int               i;
        int               r;
        int               segment;
        int               seg_len;
        int               n;
        int               arrival_pct;
        logic [CLS_W-1:0] cls;
        logic [ID_W-1:0]  id;
        logic [SVC_W-1:0] svc;

        // Drive every input from the start and hold reset, then release it
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser <= KIND_ARRIVAL;
        s_tdata <= '0;
        mismatch_count = 0;
        quiet_cycles = 0;
        items_sent = 0;
        dispatch_count = 0;
        drop_count = 0;
        burst_left = 0;
        svc_left = '0;
        tick_count = '0;
        for (i = 0; i < NUM_CLASSES; i++) begin
            class_head[i] = 0;
            class_count[i] = 0;
        end
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table: drain order, busy server, full queue, ignored tick fields
        directed_rows[0]  = stim(KIND_TICK, 2'd0, 16'h0000, 16'h0000, 8'd1, 1'b1,
                                 outcome(0, 1'b0, 1'b0, 1'b0, 16'h0000, 2'd0, 1'b0, 1'b1));
        directed_rows[1]  = stim(KIND_ARRIVAL, 2'd0, 16'h0000, 16'h0000, 8'd1, 1'b1,
                                 outcome(1, 1'b1, 1'b0, 1'b0, 16'h0000, 2'd0, 1'b0, 1'b0));
        directed_rows[2]  = stim(KIND_ARRIVAL, 2'd3, 16'hFFFF, 16'h0002, 8'd1, 1'b1,
                                 outcome(1, 1'b1, 1'b0, 1'b0, 16'h0000, 2'd0, 1'b0, 1'b0));
        directed_rows[3]  = stim(KIND_ARRIVAL, 2'd1, 16'h1234, 16'h0001, 8'd1, 1'b0, '0);
        directed_rows[4]  = stim(KIND_ARRIVAL, 2'd2, 16'h00FF, 16'h0000, 8'd1, 1'b0, '0);
        directed_rows[5]  = stim(KIND_TICK, 2'd0, 16'h0000, 16'h0000, 8'd1, 1'b1,
                                 outcome(1, 1'b0, 1'b0, 1'b1, 16'hFFFF, 2'd3, 1'b1, 1'b0));
        directed_rows[6]  = stim(KIND_TICK, 2'd0, 16'h0000, 16'h0000, 8'd1, 1'b0, '0);
        directed_rows[7]  = stim(KIND_TICK, 2'd0, 16'h0000, 16'h0000, 8'd1, 1'b0, '0);
        directed_rows[8]  = stim(KIND_TICK, 2'd0, 16'h0000, 16'h0000, 8'd1, 1'b0, '0);
        directed_rows[9]  = stim(KIND_TICK, 2'd0, 16'h0000, 16'h0000, 8'd1, 1'b0, '0);
        directed_rows[10] = stim(KIND_TICK, 2'd3, 16'hFFFF, 16'hFFFF, 8'd1, 1'b0, '0);
        directed_rows[11] = stim(KIND_ARRIVAL, 2'd1, 16'hAAAA, 16'h0001, 8'd16, 1'b0, '0);
        directed_rows[12] = stim(KIND_ARRIVAL, 2'd1, 16'h5555, 16'hFFFF, 8'd1, 1'b1,
                                 outcome(7, 1'b0, 1'b1, 1'b0, 16'h0000, 2'd0, 1'b0, 1'b0));
        directed_rows[13] = stim(KIND_ARRIVAL, 2'd3, 16'h0000, 16'h0003, 8'd1, 1'b0, '0);
        directed_rows[14] = stim(KIND_TICK, 2'd0, 16'h0000, 16'h0000, 8'd1, 1'b1,
                                 outcome(7, 1'b0, 1'b0, 1'b1, 16'h0000, 2'd3, 1'b1, 1'b0));
        directed_rows[15] = stim(KIND_TICK, 2'd0, 16'h0000, 16'h0000, 8'd1, 1'b0, '0);
        directed_rows[16] = stim(KIND_ARRIVAL, 2'd2, 16'hFFFF, 16'h0000, 8'd1, 1'b0, '0);

        for (i = 0; i < NUM_ROWS; i++) begin
            for (r = 0; r < directed_rows[i].reps; r++) begin
                send_item(directed_rows[i].kind, directed_rows[i].cls, directed_rows[i].id,
                          directed_rows[i].svc, directed_rows[i].typed, directed_rows[i].want);
            end
        end
        wait_for_results();

        // Random traffic in segments whose arrival share swings queues from full to empty
        segment = 0;
        while (items_sent < TOTAL_ITEMS) begin
            seg_len = $urandom_range(30, 120);
            case ($urandom_range(0, 3))
                0: arrival_pct = 20;
                1: arrival_pct = 50;
                2: arrival_pct = 70;
                default: arrival_pct = 90;
            endcase
            if (segment % 6 == 5) wait_for_results();
            for (n = 0; n < seg_len; n++) begin
                cls = CLS_W'($urandom_range(0, 3));
                id = ID_W'($urandom);
                if ($urandom_range(1, 100) <= arrival_pct) begin
                    // A full class drops anyway, so let its service length roam freely
                    if (class_count[cls] >= QUEUE_DEPTH) svc = SVC_W'($urandom);
                    else if ($urandom_range(0, 19) == 0) svc = SVC_W'($urandom_range(0, 40));
                    else svc = SVC_W'($urandom_range(0, 3));
                    send_item(KIND_ARRIVAL, cls, id, svc, 1'b0, '0);
                end else begin
                    svc = SVC_W'($urandom);
                    send_item(KIND_TICK, cls, id, svc, 1'b0, '0);
                end
            end
            segment++;
        end

        // Let the last results come home, then allow for the pipeline depth
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Ran %0d items over %0d ticks: %0d dispatches, %0d arrivals dropped on full",
                 items_sent, tick_count, dispatch_count, drop_count);
        $display("queues, %0d result mismatches.", mismatch_count);
        if (mismatch_count == 0) begin
            $display("strict_priority_call_scheduler_test OK");
        end else begin
            $display("strict_priority_call_scheduler_test NOT OK");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/sps_pkg.sv
hdl/sps_ram.sv
hdl/sps_queues.sv
hdl/strict_priority_call_scheduler.sv
tb/strict_priority_call_scheduler_test.sv
